>>> hw/rtl/ptt_pkg.sv
// ============================================================================
// ptt_pkg - shared types and constants of the periodic timer table
// Table size, status codes and the structures passed between the control
// logic and the timer cells.
// ============================================================================
package ptt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

    localparam int PERIOD_W = 16;
    localparam int CODE_W   = 8;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FIRED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_QUIET = 2'd3;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic tick;
        logic shift;
        logic write;
    } t_cell_ctrl;

    // Data written into the selected cell by an add transaction.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [CODE_W-1:0]   code;
    } t_entry_wr;

    // Firing report carried along the cell chain toward cell 0.
    typedef struct packed {
        logic               pend;
        logic [INDEX_W-1:0] index;
        logic [CODE_W-1:0]  code;
    } t_report;

endpackage

>>> hw/rtl/periodic_software_timer_table_top.sv
// ============================================================================
// periodic_software_timer_table_top - table of periodic timers
// Adds timers to free entries and, on each tick, counts them down and
// reports the ones that fire.
// ============================================================================
// An add transaction writes the next free cell, if any, and gives one result
// (added or table full). A tick transaction updates every cell in the cycle
// it is accepted, then the firing reports move one cell per cycle, while the
// output side is not stalled, along the cell chain to the output register.
// The walk stops as soon as no report is left behind the head of the chain,
// so a tick occupies the block for the shortest time when nothing or only
// entry 0 fires and for the longest when the highest entry fires, and for
// longer while the output side is stalled. A tick on which nothing fires gives
// a single "no firing" result. The final result of every request carries tlast.
module periodic_software_timer_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // period[15:0], action_code[23:16]
    input  logic        i_s_axis_tuser,  // req_type[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // status[1:0], timer_index[5:2],
                                         // fired_code[13:6], zero[15:14]
    output logic        o_m_axis_tlast   // last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    localparam int N = ptt_pkg::NUM_TIMERS;

    logic                           r_state;
    logic                           n_state;
    logic [ptt_pkg::CNT_W-1:0]      r_used_cnt;
    logic                           r_any;
    logic                           n_any;

    logic                           r_m_valid;
    logic                           n_m_valid;
    logic [ptt_pkg::STATUS_W-1:0]   r_status;
    logic [ptt_pkg::STATUS_W-1:0]   n_status;
    logic [ptt_pkg::INDEX_W-1:0]    r_index;
    logic [ptt_pkg::INDEX_W-1:0]    n_index;
    logic [ptt_pkg::CODE_W-1:0]     r_code;
    logic [ptt_pkg::CODE_W-1:0]     n_code;
    logic                           r_last;
    logic                           n_last;

    ptt_pkg::t_cell_ctrl            cell_ctrl;
    ptt_pkg::t_entry_wr             entry_wr;
    ptt_pkg::t_report               report [N+1];
    logic [N-1:0]                   pend_vec;
    logic [N-1:0]                   sel_vec;

    logic in_acc;
    logic out_free;
    logic is_add;
    logic full;
    logic more;

    assign out_free        = !r_m_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign is_add          = (i_s_axis_tuser == ptt_pkg::REQ_ADD);
    assign full            = (r_used_cnt == ptt_pkg::CNT_W'(N));

    assign entry_wr.period = i_s_axis_tdata[15:0];
    assign entry_wr.code   = i_s_axis_tdata[23:16];

    assign cell_ctrl.write = in_acc && is_add && !full;
    assign cell_ctrl.tick  = in_acc && (i_s_axis_tuser == ptt_pkg::REQ_TICK);
    assign cell_ctrl.shift = (r_state == ST_WALK) && out_free;

    // The last cell shifts in an empty report.
    assign report[N] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        assign sel_vec[g]  = (r_used_cnt == ptt_pkg::CNT_W'(g));
        assign pend_vec[g] = report[g].pend;

        ptt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (cell_ctrl),
            .i_sel         (sel_vec[g]),
            .i_wr          (entry_wr),
            .i_cell_index  (ptt_pkg::INDEX_W'(g)),
            .i_report_next (report[g+1]),
            .o_report      (report[g])
        );
    end

    // Reports still waiting behind the head of the chain.
    assign more = |(pend_vec >> 1);

    always_comb begin
        n_state   = r_state;
        n_any     = r_any;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_status  = r_status;
        n_index   = r_index;
        n_code    = r_code;
        n_last    = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (is_add) begin
                        n_m_valid = 1'b1;
                        n_status  = full ? ptt_pkg::STATUS_FULL : ptt_pkg::STATUS_ADDED;
                        n_index   = full ? '0 : r_used_cnt[ptt_pkg::INDEX_W-1:0];
                        n_code    = '0;
                        n_last    = 1'b1;
                    end else begin
                        n_state = ST_WALK;
                        n_any   = 1'b0;
                    end
                end
            end
            ST_WALK: begin
                if (out_free) begin
                    if (report[0].pend) begin
                        n_m_valid = 1'b1;
                        n_status  = ptt_pkg::STATUS_FIRED;
                        n_index   = report[0].index;
                        n_code    = report[0].code;
                        n_last    = !more;
                        n_any     = 1'b1;
                        if (!more) begin
                            n_state = ST_IDLE;
                        end
                    end else if (!more) begin
                        n_state = ST_IDLE;
                        if (!r_any) begin
                            n_m_valid = 1'b1;
                            n_status  = ptt_pkg::STATUS_QUIET;
                            n_index   = '0;
                            n_code    = '0;
                            n_last    = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_used_cnt <= '0;
            r_any      <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_any     <= n_any;
            r_m_valid <= n_m_valid;
            if (cell_ctrl.write) begin
                r_used_cnt <= r_used_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_index  <= n_index;
        r_code   <= n_code;
        r_last   <= n_last;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {2'b00, r_code, r_index, r_status};
    assign o_m_axis_tlast  = r_last;

`ifndef SYNTHESIS
    a_idle_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (pend_vec == '0))
        else $error("firing reports left in the chain while idle");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_cnt <= ptt_pkg::CNT_W'(N))
        else $error("timer count exceeds table size");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_add && full) |=>
            (r_m_valid && (r_status == ptt_pkg::STATUS_FULL) && r_last))
        else $error("add to a full table did not report table full");

    a_tick_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctrl.tick |=> (r_state == ST_WALK))
        else $error("tick did not start the report walk");

    a_walk_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WALK) && (n_state == ST_IDLE) && r_any && out_free
            && !report[0].pend) |-> (r_last || !r_m_valid || i_m_axis_tready))
        else $error("walk ended without a final result");
`endif

endmodule

>>> hw/rtl/ptt_cell.sv
// ============================================================================
// ptt_cell - one entry of the periodic timer table
// Holds the period, remaining count and action code of one timer, plus one
// slot of the report chain that is shifted toward cell 0 after a tick.
// ============================================================================
module ptt_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ptt_pkg::t_cell_ctrl              i_ctrl,
    input  logic                             i_sel,
    input  ptt_pkg::t_entry_wr               i_wr,
    input  logic [ptt_pkg::INDEX_W-1:0]      i_cell_index,
    input  ptt_pkg::t_report                 i_report_next,
    output ptt_pkg::t_report                 o_report
);

    logic                          r_used;
    logic [ptt_pkg::PERIOD_W-1:0]  r_reload;
    logic [ptt_pkg::PERIOD_W-1:0]  r_count;
    logic [ptt_pkg::CODE_W-1:0]    r_code;
    logic                          r_pend;
    logic [ptt_pkg::INDEX_W-1:0]   r_rep_index;
    logic [ptt_pkg::CODE_W-1:0]    r_rep_code;

    logic fire;

    assign fire = r_used && (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.write && i_sel) begin
            r_reload <= i_wr.period;
            r_count  <= i_wr.period;
            r_code   <= i_wr.code;
        end else if (i_ctrl.tick && r_used) begin
            if (fire) begin
                r_count <= r_reload;
            end else begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (i_ctrl.write && i_sel) begin
                r_used <= 1'b1;
            end
            if (i_ctrl.tick) begin
                r_pend <= fire;
            end else if (i_ctrl.shift) begin
                r_pend <= i_report_next.pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.tick) begin
            r_rep_index <= i_cell_index;
            r_rep_code  <= r_code;
        end else if (i_ctrl.shift) begin
            r_rep_index <= i_report_next.index;
            r_rep_code  <= i_report_next.code;
        end
    end

    assign o_report.pend  = r_pend;
    assign o_report.index = r_rep_index;
    assign o_report.code  = r_rep_code;

endmodule

>>> bench/testbench.sv
// ============================================================================
// testbench - self-checking bench for the periodic timer table
// Sends add and tick transactions on the input stream and predicts every
// result from a model of the timer table that runs beside the block. Each
// result on the output stream is checked field by field against the oldest
// prediction. Both stream sides idle in random bursts, and the output side
// also holds off for a long stretch so that the block stalls its input.
// ============================================================================
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BACKPRESSURE_CYCLES = 300;

    typedef struct packed {
        logic [ptt_pkg::STATUS_W-1:0] status;
        logic [ptt_pkg::INDEX_W-1:0]  index;
        logic [ptt_pkg::CODE_W-1:0]   code;
        logic                         last;
    } t_timer_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic [23:0] s_data;   // period[15:0], action_code[23:16]
    logic        s_user;   // req_type[0]
    logic        m_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;  // status[1:0], timer_index[5:2], fired_code[13:6]
    logic        o_m_axis_tlast;

    // Model of the timer table.
    logic [ptt_pkg::PERIOD_W-1:0] model_reload[ptt_pkg::NUM_TIMERS];
    logic [ptt_pkg::PERIOD_W-1:0] model_count[ptt_pkg::NUM_TIMERS];
    logic [ptt_pkg::CODE_W-1:0]   model_code[ptt_pkg::NUM_TIMERS];
    int                           model_used;

    t_timer_result pending_results[$];
    int            error_count;
    bit            send_gaps;
    bit            recv_gaps;
    int            hold_request;
    int            idle_cycles;

    periodic_software_timer_table_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Updates the table model with one request and queues the results it causes.
    function automatic void predict_timers(logic req_kind,
                                           logic [ptt_pkg::PERIOD_W-1:0] period,
                                           logic [ptt_pkg::CODE_W-1:0] code);
        t_timer_result r;
        int fire_total;
        int fire_seen;
        if (req_kind == ptt_pkg::REQ_ADD) begin
            if (model_used >= ptt_pkg::NUM_TIMERS) begin
                r = '{ptt_pkg::STATUS_FULL, '0, '0, 1'b1};
            end else begin
                model_reload[model_used] = period;
                model_count[model_used]  = period;
                model_code[model_used]   = code;
                r = '{ptt_pkg::STATUS_ADDED, model_used[ptt_pkg::INDEX_W-1:0], '0, 1'b1};
                model_used++;
            end
            pending_results.push_back(r);
        end else begin
            fire_total = 0;
            for (int j = 0; j < model_used; j++) begin
                if (model_count[j] == '0) fire_total++;
            end
            fire_seen = 0;
            for (int j = 0; j < model_used; j++) begin
                if (model_count[j] != '0) begin
                    model_count[j] = model_count[j] - 1'b1;
                end else begin
                    fire_seen++;
                    r = '{ptt_pkg::STATUS_FIRED, j[ptt_pkg::INDEX_W-1:0], model_code[j],
                          fire_seen == fire_total};
                    pending_results.push_back(r);
                    model_count[j] = model_reload[j];
                end
            end
            if (fire_total == 0) begin
                r = '{ptt_pkg::STATUS_QUIET, '0, '0, 1'b1};
                pending_results.push_back(r);
            end
        end
    endfunction

    function automatic logic [ptt_pkg::PERIOD_W-1:0] pick_period();
        // Mostly short periods so that timers fire often; now and then any value.
        if ($urandom_range(0, 7) == 0) return ptt_pkg::PERIOD_W'($urandom);
        return ptt_pkg::PERIOD_W'($urandom_range(0, 6));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic req_kind, logic [ptt_pkg::PERIOD_W-1:0] period,
                             logic [ptt_pkg::CODE_W-1:0] code);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_user  = req_kind;
        s_data  = {code, period};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_timers(req_kind, period, code);
        @(negedge i_clk);
    endtask

    task automatic send_random(int add_percent);
        if ($urandom_range(0, 99) < add_percent)
            send_item(ptt_pkg::REQ_ADD, pick_period(), ptt_pkg::CODE_W'($urandom));
        else
            send_item(ptt_pkg::REQ_TICK, ptt_pkg::PERIOD_W'($urandom),
                      ptt_pkg::CODE_W'($urandom));
    endtask

    task automatic test_empty_table_tick();
        send_item(ptt_pkg::REQ_TICK, 16'hFFFF, 8'hFF);
        send_item(ptt_pkg::REQ_TICK, 16'h0000, 8'h00);
    endtask

    task automatic test_add_extremes();
        send_item(ptt_pkg::REQ_ADD, 16'h0000, 8'hFF);
        send_item(ptt_pkg::REQ_ADD, 16'hFFFF, 8'h00);
        repeat (3) send_item(ptt_pkg::REQ_TICK, 16'h0000, 8'h00);
    endtask

    task automatic test_reload_periods();
        send_item(ptt_pkg::REQ_ADD, 16'h0001, 8'hA5);
        send_item(ptt_pkg::REQ_ADD, 16'h0002, 8'h5A);
        repeat (6) send_item(ptt_pkg::REQ_TICK, 16'h0000, 8'h00);
    endtask

    task automatic test_random_traffic(int n_items);
        repeat (n_items) send_random(15);
    endtask

    task automatic test_table_full();
        while (model_used < ptt_pkg::NUM_TIMERS)
            send_item(ptt_pkg::REQ_ADD, pick_period(), ptt_pkg::CODE_W'($urandom));
        send_item(ptt_pkg::REQ_ADD, 16'hFFFF, 8'hFF);
        send_item(ptt_pkg::REQ_ADD, 16'h0000, 8'h00);
        send_item(ptt_pkg::REQ_TICK, 16'h0000, 8'h00);
        send_item(ptt_pkg::REQ_ADD, ptt_pkg::PERIOD_W'($urandom), ptt_pkg::CODE_W'($urandom));
    endtask

    // The output side holds off while ticks keep coming, so the block fills up.
    task automatic test_output_backpressure();
        bit saved_gaps;
        saved_gaps = send_gaps;
        send_gaps = 1'b0;
        hold_request = BACKPRESSURE_CYCLES;
        repeat (40) send_random(5);
        send_gaps = saved_gaps;
    endtask

    task automatic test_steady_stream(int n_items);
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        repeat (n_items) send_random(10);
    endtask

    // Output side ready control.
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready = 1'b0;
            end else if (recv_gaps && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, expected, actual);
            error_count++;
        end
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual tdata %h tlast %b",
                         $time, o_m_axis_tdata, o_m_axis_tlast);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_m_axis_tdata[1:0]);
                check_field("timer_index", want.index, o_m_axis_tdata[5:2]);
                check_field("fired_code", want.code, o_m_axis_tdata[13:6]);
                check_field("padding", 0, o_m_axis_tdata[15:14]);
                check_field("last", want.last, o_m_axis_tlast);
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        s_user       = ptt_pkg::REQ_ADD;
        m_ready      = 1'b0;
        model_used   = 0;
        error_count  = 0;
        send_gaps    = 1'b1;
        recv_gaps    = 1'b1;
        hold_request = 0;
        idle_cycles  = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_table_tick();
        test_add_extremes();
        test_reload_periods();
        test_random_traffic(180);
        test_table_full();
        test_output_backpressure();
        test_random_traffic(160);
        test_steady_stream(80);
        s_valid = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3 * ptt_pkg::NUM_TIMERS) @(posedge i_clk);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
